### rtl/abt_pkg.sv
// abt_pkg: shared types, constants and command structs for address_ban_table.
// No dependencies.
package abt_pkg;

   localparam int ENTRIES_DEFAULT = 256;
   localparam int TIME_W = 40;
   localparam int KEY_W = 64;
   localparam int DUR_W = 32;
   localparam int REASON_W = 8;
   localparam int TYPE_W = 16;
   localparam int SCORE_W = 32;
   localparam int COUNT_W = 9;
   localparam int KIND_W = 3;

   localparam logic [KIND_W-1:0] KIND_BAN = 3'd0;
   localparam logic [KIND_W-1:0] KIND_UNBAN = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CHECK = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SWEEP = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;
   localparam logic [KIND_W-1:0] KIND_STATS = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_VICTIM,
      ST_FINISH,
      ST_READ,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;     // latch request fields, zero scan state
      logic scan_start;  // start a scan at slot 0
      logic scan_step;   // one slot visited per cycle
      logic finish;      // apply the write / removal and build the response
      logic read_hit;    // issue memory read at hit slot
      logic load_entry;  // copy read data into response
      logic rsp_load;    // response register valid
      logic rsp_clear;   // response taken
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;   // scan has evaluated the last entry
      logic need_victim; // ban of a new key on a full table
      logic need_read;   // check hit that is live
      logic rsp_valid;
   } status_type;

endpackage

### rtl/abt_ctrl.sv
// abt_ctrl: sequencing state machine for address_ban_table.
// Depends on abt_pkg.
module abt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   input  abt_pkg::status_type  stat,
   output abt_pkg::cmd_type     cmd
);
   abt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= abt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         abt_pkg::ST_IDLE: begin
            if (req_valid) state_in = abt_pkg::ST_SCAN;
         end
         abt_pkg::ST_SCAN: begin
            if (stat.scan_last) begin
               if (stat.need_victim) state_in = abt_pkg::ST_VICTIM;
               else state_in = abt_pkg::ST_FINISH;
            end
         end
         abt_pkg::ST_VICTIM: begin
            if (stat.scan_last) state_in = abt_pkg::ST_FINISH;
         end
         abt_pkg::ST_FINISH: begin
            if (stat.need_read) state_in = abt_pkg::ST_READ;
            else state_in = abt_pkg::ST_RESP;
         end
         abt_pkg::ST_READ: state_in = abt_pkg::ST_RESP;
         abt_pkg::ST_RESP: begin
            if (rsp_ready) state_in = abt_pkg::ST_IDLE;
         end
         default: state_in = abt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         abt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
         end
         abt_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.scan_start = stat.scan_last & stat.need_victim;
         end
         abt_pkg::ST_VICTIM: cmd.scan_step = 1'b1;
         abt_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            cmd.read_hit = stat.need_read;
            cmd.rsp_load = ~stat.need_read;
         end
         abt_pkg::ST_READ: begin
            cmd.load_entry = 1'b1;
            cmd.rsp_load = 1'b1;
         end
         abt_pkg::ST_RESP: cmd.rsp_clear = rsp_ready;
         default: ;
      endcase
   end
endmodule

### rtl/abt_datapath.sv
// abt_datapath: slot memories, valid bits, scan counters and response register.
// Depends on abt_pkg.
module abt_datapath #(
   parameter int ENTRIES = abt_pkg::ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  abt_pkg::cmd_type                  cmd,
   output abt_pkg::status_type               stat,
   input  logic [abt_pkg::KIND_W-1:0]        req_kind,
   input  logic [abt_pkg::TIME_W-1:0]        req_now,
   input  logic [abt_pkg::KEY_W-1:0]         req_addr_high,
   input  logic [abt_pkg::KEY_W-1:0]         req_addr_low,
   input  logic [abt_pkg::DUR_W-1:0]         req_duration,
   input  logic [abt_pkg::REASON_W-1:0]      req_reason,
   input  logic [abt_pkg::TYPE_W-1:0]        req_misbehavior_type,
   input  logic signed [abt_pkg::SCORE_W-1:0] req_score,
   output logic                              rsp_found,
   output logic                              rsp_evicted,
   output logic [abt_pkg::TIME_W-1:0]        rsp_entry_create_time,
   output logic [abt_pkg::TIME_W-1:0]        rsp_entry_ban_until,
   output logic [abt_pkg::REASON_W-1:0]      rsp_entry_reason,
   output logic [abt_pkg::TYPE_W-1:0]        rsp_entry_type,
   output logic signed [abt_pkg::SCORE_W-1:0] rsp_entry_score,
   output logic [abt_pkg::COUNT_W-1:0]       rsp_removed_count,
   output logic [abt_pkg::COUNT_W-1:0]       rsp_permanent_count,
   output logic [abt_pkg::COUNT_W-1:0]       rsp_temporary_count,
   output logic [abt_pkg::COUNT_W-1:0]       rsp_expired_count
);
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LIVE_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam int TW = abt_pkg::TIME_W;

   // slot stores (undefined until written)
   logic [abt_pkg::KEY_W-1:0]    mem_hi   [ENTRIES];
   logic [abt_pkg::KEY_W-1:0]    mem_lo   [ENTRIES];
   logic [TW-1:0]                mem_st   [ENTRIES];
   logic [TW-1:0]                mem_end  [ENTRIES];
   logic [abt_pkg::REASON_W-1:0] mem_rsn  [ENTRIES];
   logic [abt_pkg::TYPE_W-1:0]   mem_typ  [ENTRIES];
   logic [abt_pkg::SCORE_W-1:0]  mem_scr  [ENTRIES];
   logic [ENTRIES-1:0]           valid_ff;
   logic [LIVE_W-1:0]            live_ff;

   // captured request
   logic [abt_pkg::KIND_W-1:0]   kind_ff;
   logic [TW-1:0]                now_ff;
   logic [abt_pkg::KEY_W-1:0]    hi_ff, lo_ff;
   logic [abt_pkg::DUR_W-1:0]    dur_ff;
   logic [abt_pkg::REASON_W-1:0] rsn_ff;
   logic [abt_pkg::TYPE_W-1:0]   typ_ff;
   logic [abt_pkg::SCORE_W-1:0]  scr_ff;

   // scan state
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] prev_ff;    // slot whose read data is in rd_*
   logic             rd_ok_ff;   // rd_* holds a slot of this pass
   logic             pass2_ff;   // victim pass
   logic [abt_pkg::KEY_W-1:0] rd_hi_ff, rd_lo_ff;
   logic [TW-1:0]    rd_st_ff, rd_end_ff;
   logic             hit_ff, free_ff, vic_ff, vic_perm_ff;
   logic [IDX_W-1:0] hit_idx_ff, free_idx_ff, vic_idx_ff;
   logic [TW-1:0]    vic_st_ff;
   logic [abt_pkg::COUNT_W-1:0] n_perm_ff, n_temp_ff, n_exp_ff;
   logic [ENTRIES-1:0] exp_mask_ff;
   logic             tail_ff;    // last slot's data has been evaluated, scan done
   logic [TW-1:0]    mem_end_hit;

   // memory read port (registered)
   always_ff @(posedge clock) begin
      rd_hi_ff  <= mem_hi[idx_ff];
      rd_lo_ff  <= mem_lo[idx_ff];
      rd_st_ff  <= mem_st[idx_ff];
      rd_end_ff <= mem_end[idx_ff];
   end

   // evaluation of the slot whose data is registered
   logic pv, pexp, pmatch;
   assign pv = valid_ff[prev_ff];
   assign pexp = (rd_end_ff != '0) && (now_ff >= rd_end_ff);
   assign pmatch = (rd_hi_ff == hi_ff) && (rd_lo_ff == lo_ff);

   // scan ends once the final slot's data has been evaluated
   assign stat.scan_last = tail_ff;
   assign stat.need_victim = (kind_ff == abt_pkg::KIND_BAN) && !pass2_ff
                             && !(hit_ff || (rd_ok_ff && pv && pmatch))
                             && (live_ff == LIVE_W'(ENTRIES));
   assign stat.need_read = (kind_ff == abt_pkg::KIND_CHECK) && hit_ff
                           && !((mem_end_hit != '0) && (now_ff >= mem_end_hit));

   always_ff @(posedge clock) begin
      mem_end_hit <= mem_end[hit_idx_ff];
   end

   // saturating end time
   logic [TW:0] sum;
   logic [TW-1:0] end_sat;
   assign sum = {1'b0, now_ff} + (TW+1)'(dur_ff);
   assign end_sat = (dur_ff == '0) ? '0 : (sum[TW] ? '1 : sum[TW-1:0]);

   // target slot of a ban
   logic [IDX_W-1:0] tgt;
   assign tgt = hit_ff ? hit_idx_ff : (free_ff ? free_idx_ff : vic_idx_ff);
   logic do_write;
   assign do_write = cmd.finish && (kind_ff == abt_pkg::KIND_BAN);

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_hi[tgt]  <= hi_ff;
         mem_lo[tgt]  <= lo_ff;
         mem_st[tgt]  <= now_ff;
         mem_end[tgt] <= end_sat;
         mem_rsn[tgt] <= rsn_ff;
         mem_typ[tgt] <= typ_ff;
         mem_scr[tgt] <= scr_ff;
      end
   end

   logic [abt_pkg::REASON_W-1:0] hr_rsn;
   logic [abt_pkg::TYPE_W-1:0]   hr_typ;
   logic [abt_pkg::SCORE_W-1:0]  hr_scr;
   logic [TW-1:0]                hr_st, hr_end;
   always_ff @(posedge clock) begin
      if (cmd.read_hit) begin
         hr_rsn <= mem_rsn[hit_idx_ff];
         hr_typ <= mem_typ[hit_idx_ff];
         hr_scr <= mem_scr[hit_idx_ff];
         hr_st  <= mem_st[hit_idx_ff];
         hr_end <= mem_end[hit_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         now_ff  <= req_now;
         hi_ff   <= req_addr_high;
         lo_ff   <= req_addr_low;
         dur_ff  <= req_duration;
         rsn_ff  <= req_reason;
         typ_ff  <= req_misbehavior_type;
         scr_ff  <= req_score;
      end
   end

   // scan bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         rd_ok_ff <= 1'b0;
         tail_ff <= 1'b0;
         pass2_ff <= 1'b0;
      end else if (cmd.capture) begin
         idx_ff <= '0;
         rd_ok_ff <= 1'b0;
         tail_ff <= 1'b0;
         pass2_ff <= 1'b0;
         hit_ff <= 1'b0;
         free_ff <= 1'b0;
         vic_ff <= 1'b0;
         n_perm_ff <= '0;
         n_temp_ff <= '0;
         n_exp_ff <= '0;
         exp_mask_ff <= '0;
      end else if (cmd.scan_step) begin
         if (cmd.scan_start) begin
            idx_ff <= '0;
            rd_ok_ff <= 1'b0;
            tail_ff <= 1'b0;
            pass2_ff <= 1'b1;
         end else begin
            rd_ok_ff <= 1'b1;
            prev_ff <= idx_ff;
            tail_ff <= rd_ok_ff && (idx_ff == LAST_IDX) && (prev_ff == LAST_IDX);
            if (idx_ff != LAST_IDX) idx_ff <= idx_ff + 1'b1;
         end
         if (rd_ok_ff && !tail_ff && !(cmd.scan_start)) begin
            if (!pass2_ff) begin
               if (pv && pmatch && !hit_ff) begin
                  hit_ff <= 1'b1;
                  hit_idx_ff <= prev_ff;
               end
               if (!pv && !free_ff) begin
                  free_ff <= 1'b1;
                  free_idx_ff <= prev_ff;
               end
               if (pv) begin
                  if (pexp) begin
                     n_exp_ff <= n_exp_ff + 1'b1;
                     exp_mask_ff[prev_ff] <= 1'b1;
                  end else if (rd_end_ff == '0) n_perm_ff <= n_perm_ff + 1'b1;
                  else n_temp_ff <= n_temp_ff + 1'b1;
               end
            end else if (pv) begin
               // prefer non-permanent; strict less keeps the lowest slot on ties
               if (!vic_ff || (rd_end_ff != '0 && vic_perm_ff)
                   || ((rd_end_ff != '0) == !vic_perm_ff && rd_st_ff < vic_st_ff)) begin
                  vic_ff <= 1'b1;
                  vic_idx_ff <= prev_ff;
                  vic_st_ff <= rd_st_ff;
                  vic_perm_ff <= (rd_end_ff == '0);
               end
            end
         end
      end
   end

   // hit slot's end time must be read before deciding need_read; FINISH sees
   // mem_end_hit from the previous cycle, hit_idx_ff being stable by then.

   // valid bits and live count
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         live_ff <= '0;
      end else if (cmd.finish) begin
         case (kind_ff)
            abt_pkg::KIND_BAN: begin
               valid_ff[tgt] <= 1'b1;
               if (!hit_ff && free_ff) live_ff <= live_ff + 1'b1;
            end
            abt_pkg::KIND_UNBAN: begin
               if (hit_ff) begin
                  valid_ff[hit_idx_ff] <= 1'b0;
                  live_ff <= live_ff - 1'b1;
               end
            end
            abt_pkg::KIND_SWEEP: begin
               valid_ff <= valid_ff & ~exp_mask_ff;
               live_ff <= live_ff - LIVE_W'(n_exp_ff);
            end
            abt_pkg::KIND_CLEAR: begin
               valid_ff <= '0;
               live_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   // response register
   logic rv_ff;
   assign stat.rsp_valid = rv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rv_ff <= 1'b1;
      end else if (cmd.rsp_clear) begin
         rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_found <= 1'b0;
         rsp_evicted <= 1'b0;
         rsp_entry_create_time <= '0;
         rsp_entry_ban_until <= '0;
         rsp_entry_reason <= '0;
         rsp_entry_type <= '0;
         rsp_entry_score <= '0;
         rsp_removed_count <= '0;
         rsp_permanent_count <= '0;
         rsp_temporary_count <= '0;
         rsp_expired_count <= '0;
         case (kind_ff)
            abt_pkg::KIND_BAN: rsp_evicted <= !hit_ff && !free_ff;
            abt_pkg::KIND_UNBAN: rsp_found <= hit_ff;
            abt_pkg::KIND_SWEEP: rsp_removed_count <= n_exp_ff;
            abt_pkg::KIND_STATS: begin
               rsp_permanent_count <= n_perm_ff;
               rsp_temporary_count <= n_temp_ff;
               rsp_expired_count <= n_exp_ff;
            end
            default: ;
         endcase
      end else if (cmd.load_entry) begin
         rsp_found <= 1'b1;
         rsp_entry_create_time <= hr_st;
         rsp_entry_ban_until <= hr_end;
         rsp_entry_reason <= hr_rsn;
         rsp_entry_type <= hr_typ;
         rsp_entry_score <= hr_scr;
      end
   end
endmodule

### rtl/address_ban_table.sv
// address_ban_table: one transaction at a time. Each transaction scans all slots
// through a registered memory read port, then takes a finish step before rsp_valid
// rises. A ban that must evict scans twice. A check of a live entry adds a payload
// read. A new request is taken only after the response has been accepted.
// Reset clears valid bits, live count and control; slot payload needs none.
module address_ban_table #(
   parameter int ENTRIES = abt_pkg::ENTRIES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [abt_pkg::KIND_W-1:0]         req_kind,
   input  logic [abt_pkg::TIME_W-1:0]         req_now,
   input  logic [abt_pkg::KEY_W-1:0]          req_addr_high,
   input  logic [abt_pkg::KEY_W-1:0]          req_addr_low,
   input  logic [abt_pkg::DUR_W-1:0]          req_duration,
   input  logic [abt_pkg::REASON_W-1:0]       req_reason,
   input  logic [abt_pkg::TYPE_W-1:0]         req_misbehavior_type,
   input  logic signed [abt_pkg::SCORE_W-1:0] req_score,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_found,
   output logic                               rsp_evicted,
   output logic [abt_pkg::TIME_W-1:0]         rsp_entry_create_time,
   output logic [abt_pkg::TIME_W-1:0]         rsp_entry_ban_until,
   output logic [abt_pkg::REASON_W-1:0]       rsp_entry_reason,
   output logic [abt_pkg::TYPE_W-1:0]         rsp_entry_type,
   output logic signed [abt_pkg::SCORE_W-1:0] rsp_entry_score,
   output logic [abt_pkg::COUNT_W-1:0]        rsp_removed_count,
   output logic [abt_pkg::COUNT_W-1:0]        rsp_permanent_count,
   output logic [abt_pkg::COUNT_W-1:0]        rsp_temporary_count,
   output logic [abt_pkg::COUNT_W-1:0]        rsp_expired_count
);
   abt_pkg::cmd_type    cmd;
   abt_pkg::status_type stat;

   // controller walks scan / victim / finish / respond
   abt_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_ready(rsp_ready), .stat(stat), .cmd(cmd)
   );

   // datapath owns slot memories, valid bits and the response register
   abt_datapath #(.ENTRIES(ENTRIES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_kind(req_kind), .req_now(req_now),
      .req_addr_high(req_addr_high), .req_addr_low(req_addr_low),
      .req_duration(req_duration), .req_reason(req_reason),
      .req_misbehavior_type(req_misbehavior_type), .req_score(req_score),
      .rsp_found(rsp_found), .rsp_evicted(rsp_evicted),
      .rsp_entry_create_time(rsp_entry_create_time),
      .rsp_entry_ban_until(rsp_entry_ban_until),
      .rsp_entry_reason(rsp_entry_reason), .rsp_entry_type(rsp_entry_type),
      .rsp_entry_score(rsp_entry_score), .rsp_removed_count(rsp_removed_count),
      .rsp_permanent_count(rsp_permanent_count),
      .rsp_temporary_count(rsp_temporary_count),
      .rsp_expired_count(rsp_expired_count)
   );

   assign rsp_valid = stat.rsp_valid;
endmodule

### rtl/abt_checker.sv
// abt_checker: port-level assertions for address_ban_table, bound to the top.
// Depends on the top level's ports only.
module abt_port_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_found,
   input logic rsp_evicted
);
   // one transaction in flight: no new request while a response waits
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("request taken with response pending");
   // rsp_valid stays low just after a request is accepted
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("response too early");
   // found and evicted never both set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_evicted))
      else $error("found and evicted together");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped");
endmodule

bind address_ban_table abt_port_checker u_abt_port_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_found(rsp_found), .rsp_evicted(rsp_evicted)
);

### tb/abt_checker.sv
// abt_checker: watches both channels of address_ban_table, predicts each response
// from its own copy of the ban table and compares field by field.
// Depends on abt_pkg for widths and kind codes.
module abt_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [abt_pkg::KIND_W-1:0]         req_kind,
   input  logic [abt_pkg::TIME_W-1:0]         req_now,
   input  logic [abt_pkg::KEY_W-1:0]          req_addr_high,
   input  logic [abt_pkg::KEY_W-1:0]          req_addr_low,
   input  logic [abt_pkg::DUR_W-1:0]          req_duration,
   input  logic [abt_pkg::REASON_W-1:0]       req_reason,
   input  logic [abt_pkg::TYPE_W-1:0]         req_misbehavior_type,
   input  logic signed [abt_pkg::SCORE_W-1:0] req_score,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               rsp_found,
   input  logic                               rsp_evicted,
   input  logic [abt_pkg::TIME_W-1:0]         rsp_entry_create_time,
   input  logic [abt_pkg::TIME_W-1:0]         rsp_entry_ban_until,
   input  logic [abt_pkg::REASON_W-1:0]       rsp_entry_reason,
   input  logic [abt_pkg::TYPE_W-1:0]         rsp_entry_type,
   input  logic signed [abt_pkg::SCORE_W-1:0] rsp_entry_score,
   input  logic [abt_pkg::COUNT_W-1:0]        rsp_removed_count,
   input  logic [abt_pkg::COUNT_W-1:0]        rsp_permanent_count,
   input  logic [abt_pkg::COUNT_W-1:0]        rsp_temporary_count,
   input  logic [abt_pkg::COUNT_W-1:0]        rsp_expired_count,
   output int                                 fail_count,
   output int                                 pending
);
   import abt_pkg::*;

   localparam int SLOTS = ENTRIES_DEFAULT;

   typedef struct packed {
      logic                found;
      logic                evicted;
      logic [TIME_W-1:0]   create_time;
      logic [TIME_W-1:0]   ban_until;
      logic [REASON_W-1:0] reason;
      logic [TYPE_W-1:0]   mtype;
      logic [SCORE_W-1:0]  score;
      logic [COUNT_W-1:0]  removed;
      logic [COUNT_W-1:0]  permanent;
      logic [COUNT_W-1:0]  temporary;
      logic [COUNT_W-1:0]  expired;
   } ban_rsp_type;

   // shadow ban table
   logic                tbl_valid [SLOTS];
   logic [KEY_W-1:0]    tbl_hi    [SLOTS];
   logic [KEY_W-1:0]    tbl_lo    [SLOTS];
   logic [TIME_W-1:0]   tbl_start [SLOTS];
   logic [TIME_W-1:0]   tbl_end   [SLOTS];
   logic [REASON_W-1:0] tbl_reason[SLOTS];
   logic [TYPE_W-1:0]   tbl_type  [SLOTS];
   logic [SCORE_W-1:0]  tbl_score [SLOTS];
   int                  tbl_live;

   ban_rsp_type expected_rsps[$];
   int          reported;

   function automatic bit lapsed(int s, logic [TIME_W-1:0] now);
      return tbl_end[s] != '0 && now >= tbl_end[s];
   endfunction

   function automatic int lookup(logic [KEY_W-1:0] hi, logic [KEY_W-1:0] lo);
      for (int s = 0; s < SLOTS; s++)
         if (tbl_valid[s] && tbl_hi[s] == hi && tbl_lo[s] == lo) return s;
      return -1;
   endfunction

   // oldest temporary entry first, else oldest permanent; ties go to lowest slot
   function automatic int oldest_victim();
      int best;
      best = -1;
      for (int s = 0; s < SLOTS; s++)
         if (tbl_valid[s] && tbl_end[s] != '0 &&
             (best < 0 || tbl_start[s] < tbl_start[best])) best = s;
      if (best >= 0) return best;
      for (int s = 0; s < SLOTS; s++)
         if (tbl_valid[s] && (best < 0 || tbl_start[s] < tbl_start[best])) best = s;
      return best;
   endfunction

   task automatic apply_ban_op(output ban_rsp_type r);
      int              hit, slot;
      logic [TIME_W:0] end_val;
      int              n0, n1, n2;
      r = '0;
      n0 = 0; n1 = 0; n2 = 0;
      hit = lookup(req_addr_high, req_addr_low);
      case (req_kind)
         KIND_BAN: begin
            if (hit >= 0) slot = hit;
            else if (tbl_live < SLOTS) begin
               slot = 0;
               while (tbl_valid[slot]) slot++;
               tbl_live++;
            end else begin
               slot = oldest_victim();
               r.evicted = 1'b1;
            end
            end_val = '0;
            if (req_duration != '0) begin
               end_val = {1'b0, req_now} + req_duration;
               if (end_val[TIME_W]) end_val = {1'b0, {TIME_W{1'b1}}};
            end
            tbl_valid[slot]  = 1'b1;
            tbl_hi[slot]     = req_addr_high;
            tbl_lo[slot]     = req_addr_low;
            tbl_start[slot]  = req_now;
            tbl_end[slot]    = end_val[TIME_W-1:0];
            tbl_reason[slot] = req_reason;
            tbl_type[slot]   = req_misbehavior_type;
            tbl_score[slot]  = req_score;
         end
         KIND_UNBAN: begin
            if (hit >= 0) begin
               tbl_valid[hit] = 1'b0;
               tbl_live--;
               r.found = 1'b1;
            end
         end
         KIND_CHECK: begin
            if (hit >= 0 && !lapsed(hit, req_now)) begin
               r.found       = 1'b1;
               r.create_time = tbl_start[hit];
               r.ban_until   = tbl_end[hit];
               r.reason      = tbl_reason[hit];
               r.mtype       = tbl_type[hit];
               r.score       = tbl_score[hit];
            end
         end
         KIND_SWEEP: begin
            for (int s = 0; s < SLOTS; s++)
               if (tbl_valid[s] && lapsed(s, req_now)) begin
                  tbl_valid[s] = 1'b0;
                  tbl_live--;
                  n0++;
               end
            r.removed = n0[COUNT_W-1:0];
         end
         KIND_CLEAR: begin
            for (int s = 0; s < SLOTS; s++) tbl_valid[s] = 1'b0;
            tbl_live = 0;
         end
         KIND_STATS: begin
            for (int s = 0; s < SLOTS; s++)
               if (tbl_valid[s]) begin
                  if (lapsed(s, req_now)) n2++;
                  else if (tbl_end[s] == '0) n0++;
                  else n1++;
               end
            r.permanent = n0[COUNT_W-1:0];
            r.temporary = n1[COUNT_W-1:0];
            r.expired   = n2[COUNT_W-1:0];
         end
         default: ;
      endcase
   endtask

   task automatic cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v,
                            inout bit bad);
      if (act_v !== exp_v) begin
         bad = 1'b1;
         if (reported < 10) begin
            reported++;
            $display("mismatch %s: expected %0h actual %0h", name, exp_v, act_v);
         end
      end
   endtask

   initial begin
      fail_count = 0;
      reported = 0;
      tbl_live = 0;
      for (int s = 0; s < SLOTS; s++) tbl_valid[s] = 1'b0;
   end

   assign pending = expected_rsps.size();

   always @(posedge clock) begin
      ban_rsp_type e, a;
      bit          bad;
      if (!reset) begin
         // response first; block holds one transaction at a time
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (reported < 10) begin
                  reported++;
                  $display("response with no transaction outstanding");
               end
            end else begin
               e = expected_rsps.pop_front();
               a = '{rsp_found, rsp_evicted, rsp_entry_create_time, rsp_entry_ban_until,
                     rsp_entry_reason, rsp_entry_type, rsp_entry_score, rsp_removed_count,
                     rsp_permanent_count, rsp_temporary_count, rsp_expired_count};
               bad = 1'b0;
               cmp_field("found", e.found, a.found, bad);
               cmp_field("evicted", e.evicted, a.evicted, bad);
               cmp_field("entry_create_time", e.create_time, a.create_time, bad);
               cmp_field("entry_ban_until", e.ban_until, a.ban_until, bad);
               cmp_field("entry_reason", e.reason, a.reason, bad);
               cmp_field("entry_type", e.mtype, a.mtype, bad);
               cmp_field("entry_score", e.score, a.score, bad);
               cmp_field("removed_count", e.removed, a.removed, bad);
               cmp_field("permanent_count", e.permanent, a.permanent, bad);
               cmp_field("temporary_count", e.temporary, a.temporary, bad);
               cmp_field("expired_count", e.expired, a.expired, bad);
               if (bad) fail_count++;
            end
         end
         if (req_valid && req_ready) begin
            apply_ban_op(e);
            expected_rsps.push_back(e);
         end
      end
   end

endmodule

### tb/tb_top.sv
// tb_top: stimulus and verdict for address_ban_table; abt_checker does prediction.
// Depends on abt_pkg, address_ban_table and abt_checker.
module tb_top;
   import abt_pkg::*;

   localparam int NUM_ITEMS = 1900;
   localparam int CYCLE_LIMIT = 6000000;   // plenty of slack
   localparam int POOL_N = 24;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [KIND_W-1:0]     req_kind;
   logic [TIME_W-1:0]     req_now;
   logic [KEY_W-1:0]      req_addr_high;
   logic [KEY_W-1:0]      req_addr_low;
   logic [DUR_W-1:0]      req_duration;
   logic [REASON_W-1:0]   req_reason;
   logic [TYPE_W-1:0]     req_misbehavior_type;
   logic signed [SCORE_W-1:0] req_score;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_found;
   logic                  rsp_evicted;
   logic [TIME_W-1:0]     rsp_entry_create_time;
   logic [TIME_W-1:0]     rsp_entry_ban_until;
   logic [REASON_W-1:0]   rsp_entry_reason;
   logic [TYPE_W-1:0]     rsp_entry_type;
   logic signed [SCORE_W-1:0] rsp_entry_score;
   logic [COUNT_W-1:0]    rsp_removed_count;
   logic [COUNT_W-1:0]    rsp_permanent_count;
   logic [COUNT_W-1:0]    rsp_temporary_count;
   logic [COUNT_W-1:0]    rsp_expired_count;

   int fail_count;
   int pending;
   int cycles;
   int sent;
   int stall_mode;

   // small set of recurring addresses so unban/check actually hit
   logic [KEY_W-1:0]  pool_hi [POOL_N];
   logic [KEY_W-1:0]  pool_lo [POOL_N];
   logic [TIME_W-1:0] clk_now;   // running wall time

   address_ban_table dut (.*);

   abt_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // response backpressure: free-flowing, light or heavy stall, switched now and then
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 9) < 2);
      endcase
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   // one transaction: optional idle gap, then hold valid until accepted
   task automatic send(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] now,
                       logic [KEY_W-1:0] hi, logic [KEY_W-1:0] lo,
                       logic [DUR_W-1:0] dur, logic [REASON_W-1:0] rsn,
                       logic [TYPE_W-1:0] mtype, logic [SCORE_W-1:0] scr);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_now <= now;
      req_addr_high <= hi;
      req_addr_low <= lo;
      req_duration <= dur;
      req_reason <= rsn;
      req_misbehavior_type <= mtype;
      req_score <= scr;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [DUR_W-1:0] rand_dur();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return '0;
      if (r < 7) return $urandom_range(1, 50);
      return $urandom;
   endfunction

   // mostly creeping time, now and then an arbitrary 40-bit instant
   function automatic logic [TIME_W-1:0] pick_now();
      if ($urandom_range(0, 39) == 0) return TIME_W'({$urandom, $urandom});
      return clk_now;
   endfunction

   task automatic random_op();
      int               r, p;
      logic [KIND_W-1:0] k;
      logic [KEY_W-1:0] hi, lo;
      r = $urandom_range(0, 99);
      if (r < 32)      k = KIND_BAN;
      else if (r < 44) k = KIND_UNBAN;
      else if (r < 70) k = KIND_CHECK;
      else if (r < 79) k = KIND_SWEEP;
      else if (r < 82) k = KIND_CLEAR;
      else if (r < 96) k = KIND_STATS;
      else             k = KIND_W'($urandom_range(6, 7));
      p = $urandom_range(0, POOL_N - 1);
      if ($urandom_range(0, 4) == 0) begin
         hi = rand64();
         lo = rand64();
      end else begin
         hi = pool_hi[p];
         lo = pool_lo[p];
      end
      clk_now = clk_now + TIME_W'($urandom_range(0, 6));
      send(k, pick_now(), hi, lo, rand_dur(), REASON_W'($urandom),
           TYPE_W'($urandom), $urandom);
   endtask

   // fill past capacity with fresh addresses so full-table eviction gets exercised;
   // repeated instants create creation-time ties
   task automatic fill_table(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 2) == 0) clk_now = clk_now + TIME_W'($urandom_range(1, 4));
         send(KIND_BAN, clk_now, rand64(), rand64(),
              ($urandom_range(0, 3) == 0) ? '0 : rand_dur(),
              REASON_W'($urandom), TYPE_W'($urandom), $urandom);
      end
   endtask

   initial begin
      cycles = 0;
      sent = 0;
      stall_mode = 0;
      clk_now = 40'd1000;
      reset <= 1'b1;
      req_valid <= 1'b0;
      rsp_ready <= 1'b1;
      req_kind <= KIND_STATS;
      req_now <= '0;
      req_addr_high <= '0;
      req_addr_low <= '0;
      req_duration <= '0;
      req_reason <= '0;
      req_misbehavior_type <= '0;
      req_score <= '0;
      for (int i = 0; i < POOL_N; i++) begin
         pool_hi[i] = rand64();
         pool_lo[i] = rand64();
      end
      pool_hi[0] = '0;
      pool_lo[0] = '0;
      pool_hi[1] = '1;
      pool_lo[1] = '1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, permanent vs temporary, expiry boundary,
      // unban of an expired entry, saturated end time, field extremes, odd kinds
      send(KIND_STATS, 40'd0, '0, '0, '0, '0, '0, '0);
      send(KIND_BAN, 40'd50, pool_hi[0], pool_lo[0], '0, 8'h00, 16'h0000, 32'h8000_0000);
      send(KIND_BAN, 40'd100, pool_hi[1], pool_lo[1], 32'd10, 8'hff, 16'hffff, 32'h7fff_ffff);
      send(KIND_CHECK, 40'd109, pool_hi[1], pool_lo[1], '0, '0, '0, '0);
      send(KIND_CHECK, 40'd110, pool_hi[1], pool_lo[1], '0, '0, '0, '0);
      send(KIND_STATS, 40'd110, '0, '0, '0, '0, '0, '0);
      send(KIND_UNBAN, 40'd110, pool_hi[1], pool_lo[1], '0, '0, '0, '0);
      send(KIND_UNBAN, 40'd110, pool_hi[1], pool_lo[1], '0, '0, '0, '0);
      send(KIND_BAN, 40'hff_ffff_ff00, pool_hi[2], pool_lo[2], 32'hffff_ffff,
           8'h5a, 16'ha5a5, 32'hffff_ffff);
      send(KIND_CHECK, 40'hff_ffff_fffe, pool_hi[2], pool_lo[2], '0, '0, '0, '0);
      send(KIND_BAN, 40'd200, pool_hi[3], pool_lo[3], 32'd1, 8'h11, 16'h2222, 32'd5);
      send(KIND_BAN, 40'd210, pool_hi[3], pool_lo[3], 32'd300, 8'h33, 16'h4444, -32'sd7);
      send(KIND_CHECK, 40'd211, pool_hi[3], pool_lo[3], '0, '0, '0, '0);
      send(KIND_CHECK, 40'd211, pool_hi[0], pool_lo[0], '0, '0, '0, '0);
      send(KIND_SWEEP, 40'hff_ffff_ffff, '1, '1, '1, '1, '1, '1);
      send(KIND_STATS, 40'd300, '0, '0, '0, '0, '0, '0);
      send(3'd6, 40'd300, pool_hi[0], pool_lo[0], 32'd9, 8'h1, 16'h1, 32'd1);
      send(3'd7, 40'hff_ffff_ffff, '1, '1, '1, '1, '1, '1);
      send(KIND_CLEAR, 40'd300, '0, '0, '0, '0, '0, '0);
      send(KIND_STATS, 40'd300, '0, '0, '0, '0, '0, '0);
      send(KIND_CHECK, 40'd300, pool_hi[0], pool_lo[0], '0, '0, '0, '0);

      // random: ordinary traffic with occasional over-capacity fills
      while (sent < NUM_ITEMS) begin
         if ($urandom_range(0, 99) < 2 && sent + 300 < NUM_ITEMS)
            fill_table($urandom_range(250, 290));
         else
            random_op();
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
